[src/hashed_proxy_tuple_table_top_assert.svh]
// Assertion macros used by the checker file of the proxy tuple table.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef HASHED_PROXY_TUPLE_TABLE_TOP_ASSERT_SVH
`define HASHED_PROXY_TUPLE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define HPTT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/hptt_pkg.sv]
// ----------------------------------------------------------------------------
// hptt_pkg
// Types, codes and the bucket fold shared by the proxy tuple table files.
// ----------------------------------------------------------------------------
`default_nettype none

package hptt_pkg;

  // Operation codes of an input beat.
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_LOOKUP_HIT  = 3'd0,
    STATUS_LOOKUP_MISS = 3'd1,
    STATUS_INSERTED    = 3'd2,
    STATUS_PRESENT     = 3'd3,
    STATUS_FULL        = 3'd4
  } status_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READ,
    ST_EVAL
  } state_t;

  localparam int unsigned KEY_W   = 48;
  localparam int unsigned VALUE_W = 48;
  localparam int unsigned ENTRY_W = KEY_W + VALUE_W;

  localparam logic [31:0] FOLD_KEEP_MASK = 32'h1fff_ffff;
  localparam logic [31:0] FOLD_HIGH_MASK = 32'he000_0000;
  localparam int unsigned FOLD_SHIFT     = 3;

  localparam logic [7:0] PROTO_TCP = 8'd6;

  // One queued request.
  typedef struct packed {
    op_t         operation;
    logic [31:0] key_ip;
    logic [15:0] key_port;
    logic [7:0]  proto_in;
    logic [31:0] proxy_ip;
    logic [15:0] proxy_port;
  } req_t;

  // Fold the top three address bits into bits 28..26.
  function automatic logic [31:0] fold_ip(input logic [31:0] ip);
    fold_ip = (ip & FOLD_KEEP_MASK) | ((ip & FOLD_HIGH_MASK) >> FOLD_SHIFT);
  endfunction

endpackage

`default_nettype wire

[src/hptt_ram.sv]
// ----------------------------------------------------------------------------
// hptt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/hptt_front.sv]
// ----------------------------------------------------------------------------
// hptt_front
// Accepts input beats, computes the bucket index and queues the requests.
// ----------------------------------------------------------------------------
`default_nettype none

module hptt_front #(
  parameter int unsigned BUCKET_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   enable,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire hptt_pkg::req_t         in_req,
  output logic                        q_valid,
  output hptt_pkg::req_t              q_req,
  output logic [BUCKET_BITS-1:0]      q_bucket,
  input  wire logic                   q_pop
);
  import hptt_pkg::*;

  localparam int unsigned QDEPTH = 2;

  req_t                   q_entry  [QDEPTH];
  logic [BUCKET_BITS-1:0] q_bkt    [QDEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;
  logic [31:0]            folded;

  // Bucket index of the incoming key.
  assign folded   = fold_ip(in_req.key_ip);
  assign in_ready = enable && (count != 2'(QDEPTH));
  assign push     = in_valid && in_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_entry[wr_ptr] <= in_req;
      q_bkt[wr_ptr]   <= folded[BUCKET_BITS-1:0];
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid  = (count != 2'd0);
  assign q_req    = q_entry[rd_ptr];
  assign q_bucket = q_bkt[rd_ptr];

endmodule

`default_nettype wire

[src/hptt_back.sv]
// ----------------------------------------------------------------------------
// hptt_back
// Reads a bucket, matches the key across its ways, writes back inserts and
// holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hptt_back #(
  parameter int unsigned BUCKET_BITS = 8,
  parameter int unsigned WAYS        = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  output logic                        ready_for_items,
  input  wire logic                   q_valid,
  input  wire hptt_pkg::req_t         q_req,
  input  wire logic [BUCKET_BITS-1:0] q_bucket,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        hit,
  output logic [2:0]                  status,
  output logic [31:0]                 found_listen_ip,
  output logic [15:0]                 found_listen_port,
  output logic [7:0]                  found_proto
);
  import hptt_pkg::*;

  localparam int unsigned NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int unsigned ROW_W       = WAYS * ENTRY_W;

  state_t                 state;
  state_t                 state_next;
  logic [BUCKET_BITS-1:0] clear_addr;
  req_t                   cur;
  logic [BUCKET_BITS-1:0] cur_bucket;

  logic [WAYS-1:0]        vld_row;
  logic [ROW_W-1:0]       data_row;
  logic                   vld_we;
  logic [BUCKET_BITS-1:0] vld_waddr;
  logic [WAYS-1:0]        vld_wdata;
  logic                   data_we;
  logic [ROW_W-1:0]       data_wdata;
  logic                   rd_en;

  logic                   load;
  logic                   match_any;
  logic                   free_any;
  logic [WAYS-1:0]        free_oh;
  logic [VALUE_W-1:0]     match_value;
  logic [KEY_W-1:0]       cur_key;
  logic [VALUE_W-1:0]     cur_value;

  logic                   hit_next;
  status_t                status_next;
  logic [VALUE_W-1:0]     value_next;
  logic [7:0]             proto_next;

  // Valid mask of each bucket, cleared by a sweep after reset.
  hptt_ram #(
    .WIDTH (WAYS),
    .DEPTH (NUM_BUCKETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (rd_en),
    .raddr (q_bucket),
    .rdata (vld_row)
  );

  // Keys and listen values of each bucket.
  hptt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (cur_bucket),
    .wdata (data_wdata),
    .re    (rd_en),
    .raddr (q_bucket),
    .rdata (data_row)
  );

  assign cur_key   = {cur.key_ip, cur.key_port};
  assign cur_value = {cur.proxy_ip, cur.proxy_port};

  // First matching way and first free way of the bucket.
  always_comb begin
    match_any   = 1'b0;
    free_any    = 1'b0;
    free_oh     = '0;
    match_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vld_row[w]) begin
        if (!match_any && (data_row[w*ENTRY_W+VALUE_W +: KEY_W] == cur_key)) begin
          match_any   = 1'b1;
          match_value = data_row[w*ENTRY_W +: VALUE_W];
        end
      end else if (!free_any) begin
        free_any   = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
  end

  // Merge the new entry into the row that was read.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (free_oh[w]) begin
        data_wdata[w*ENTRY_W +: ENTRY_W] = {cur_key, cur_value};
      end else begin
        data_wdata[w*ENTRY_W +: ENTRY_W] = data_row[w*ENTRY_W +: ENTRY_W];
      end
    end
  end

  // Result of the current request.
  always_comb begin
    hit_next    = 1'b0;
    status_next = STATUS_LOOKUP_MISS;
    value_next  = '0;
    proto_next  = '0;
    if (cur.operation == OP_LOOKUP) begin
      if (match_any && (cur.proto_in != 8'd0)) begin
        hit_next    = 1'b1;
        status_next = STATUS_LOOKUP_HIT;
        value_next  = match_value;
        proto_next  = PROTO_TCP;
      end
    end else if (match_any) begin
      hit_next    = 1'b1;
      status_next = STATUS_PRESENT;
      value_next  = match_value;
      proto_next  = PROTO_TCP;
    end else if (free_any) begin
      status_next = STATUS_INSERTED;
    end else begin
      status_next = STATUS_FULL;
    end
  end

  // Sequencer: clear sweep, bucket read, evaluate and write back.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == '1) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = ST_READ;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign data_we   = load && (cur.operation == OP_INSERT) && !match_any && free_any;
  assign vld_we    = (state == ST_CLEAR) || data_we;
  assign vld_waddr = (state == ST_CLEAR) ? clear_addr : cur_bucket;
  assign vld_wdata = (state == ST_CLEAR) ? '0 : (vld_row | free_oh);

  assign ready_for_items = (state != ST_CLEAR);

  // State and sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Request held while its bucket is evaluated.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur        <= q_req;
      cur_bucket <= q_bucket;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit               <= hit_next;
      status            <= 3'(status_next);
      found_listen_ip   <= value_next[VALUE_W-1:16];
      found_listen_port <= value_next[15:0];
      found_proto       <= proto_next;
    end
  end

endmodule

`default_nettype wire

[src/hashed_proxy_tuple_table_top.sv]
// Flow: an accepted input beat is queued, its bucket is read from the bucket RAM,
// and the evaluate and write-back step registers the result beat. The back end
// reads the next bucket only after that step, which waits on a stalled result.
// Reset: rst clears control state, then a sweep over all 2**BUCKET_BITS buckets
// zeroes the valid masks; in_ready stays low until the sweep is done.
// ----------------------------------------------------------------------------
// hashed_proxy_tuple_table_top
// Exact-match table from upstream server address and port to proxy listen tuple.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_proxy_tuple_table_top #(
  parameter int unsigned BUCKET_BITS = 8,
  parameter int unsigned WAYS        = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] key_ip,
  input  wire logic [15:0] key_port,
  input  wire logic [7:0]  proto_in,
  input  wire logic [31:0] new_listen_ip,
  input  wire logic [15:0] new_listen_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit,
  output logic [2:0]       status,
  output logic [31:0]      found_listen_ip,
  output logic [15:0]      found_listen_port,
  output logic [7:0]       found_proto
);
  import hptt_pkg::*;

  req_t                   in_req;
  req_t                   q_req;
  logic [BUCKET_BITS-1:0] q_bucket;
  logic                   q_valid;
  logic                   q_pop;
  logic                   ready_for_items;

  // Pack the input beat.
  always_comb begin
    in_req.operation  = op_t'(operation);
    in_req.key_ip     = key_ip;
    in_req.key_port   = key_port;
    in_req.proto_in   = proto_in;
    in_req.proxy_ip   = new_listen_ip;
    in_req.proxy_port = new_listen_port;
  end

  hptt_front #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (ready_for_items),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_bucket (q_bucket),
    .q_pop    (q_pop)
  );

  hptt_back #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .ready_for_items   (ready_for_items),
    .q_valid           (q_valid),
    .q_req             (q_req),
    .q_bucket          (q_bucket),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hit               (hit),
    .status            (status),
    .found_listen_ip   (found_listen_ip),
    .found_listen_port (found_listen_port),
    .found_proto       (found_proto)
  );

endmodule

`default_nettype wire

[src/hptt_checker.sv]
// ----------------------------------------------------------------------------
// hptt_checker
// Port-level checks of the result beats of the proxy tuple table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_proxy_tuple_table_top_assert.svh"

module hptt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        hit,
  input wire logic [2:0]  status,
  input wire logic [31:0] found_listen_ip,
  input wire logic [15:0] found_listen_port,
  input wire logic [7:0]  found_proto
);
  import hptt_pkg::*;

  // A stalled result beat holds its status, hit flag and listen address and port.
  `HPTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(hit) && $stable(found_listen_ip) && $stable(found_listen_port), "result beat changed while stalled")

  // The hit flag agrees with the status code.
  `HPTT_ASSERT_IMPL(a_hit_status, out_valid, hit == ((status == STATUS_LOOKUP_HIT) || (status == STATUS_PRESENT)), "hit flag disagrees with status")

  // A miss, an insert or a full bucket returns an all-zero tuple.
  `HPTT_ASSERT_IMPL(a_miss_zero, out_valid && !hit, (found_listen_ip == 32'd0) && (found_listen_port == 16'd0) && (found_proto == 8'd0), "nonzero tuple on a result without hit")

  // A matched entry always reports the TCP protocol code.
  `HPTT_ASSERT_IMPL(a_hit_proto, out_valid && hit, found_proto == PROTO_TCP, "wrong protocol on a hit")

endmodule

bind hashed_proxy_tuple_table_top hptt_checker u_checker (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookup and insert beats into the proxy tuple table, predicts every
// result from a software copy of the buckets, and checks each result beat
// field by field under random idling, a long output stall and phase pauses.
// ----------------------------------------------------------------------------

module testbench;
  import hptt_pkg::*;

  localparam int unsigned BUCKET_BITS = 8;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int unsigned NUM_SLOTS   = NUM_BUCKETS * WAYS;
  localparam int          POOL_SIZE   = 40;
  localparam int          PHASE_BEATS = 216;
  localparam int          STALL_LEN   = 300;
  localparam int          TAIL_CYCLES = 20;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_PRINTS  = 40;

  // One request beat and one result beat.
  typedef struct {
    op_t         op;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  proto;
    logic [31:0] proxy_ip;
    logic [15:0] proxy_port;
  } request_t;

  typedef struct {
    logic        hit;
    status_t     status;
    logic [31:0] proxy_ip;
    logic [15:0] proxy_port;
    logic [7:0]  proto;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        operation       = 1'b0;
  logic [31:0] key_ip          = '0;
  logic [15:0] key_port        = '0;
  logic [7:0]  proto_in        = '0;
  logic [31:0] new_listen_ip   = '0;
  logic [15:0] new_listen_port = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        hit;
  logic [2:0]  status;
  logic [31:0] found_listen_ip;
  logic [15:0] found_listen_port;
  logic [7:0]  found_proto;

  hashed_proxy_tuple_table_top #(
    .BUCKET_BITS(BUCKET_BITS),
    .WAYS       (WAYS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .key_ip           (key_ip),
    .key_port         (key_port),
    .proto_in         (proto_in),
    .new_listen_ip    (new_listen_ip),
    .new_listen_port  (new_listen_port),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .status           (status),
    .found_listen_ip  (found_listen_ip),
    .found_listen_port(found_listen_port),
    .found_proto      (found_proto)
  );

  // Software copy of the table.
  bit          shadow_valid [NUM_SLOTS];
  logic [47:0] shadow_key   [NUM_SLOTS];
  logic [47:0] shadow_value [NUM_SLOTS];

  request_t pending_requests[$];
  reply_t   expected_replies[$];

  logic [31:0] pool_ip   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int beats_in      = 0;
  int beats_out     = 0;
  int status_seen [5];

  logic in_taken     = 1'b0;
  logic stall_armed  = 1'b0;
  int   stall_cycles = 0;

  // Fold the top address bits down and keep the bucket bits.
  function automatic int unsigned bucket_index(input logic [31:0] ip);
    logic [31:0] folded;
    folded = (ip & 32'h1fff_ffff) | ((ip & 32'he000_0000) >> 3);
    return folded & (NUM_BUCKETS - 1);
  endfunction

  // Apply one request to the shadow table and return the reply it causes.
  function automatic reply_t table_apply(input request_t req);
    int unsigned base;
    int          match_slot;
    int          free_slot;
    logic [47:0] req_key;
    reply_t      r;
    base       = bucket_index(req.ip) * WAYS;
    match_slot = -1;
    free_slot  = -1;
    req_key    = {req.ip, req.port};
    r.hit        = 1'b0;
    r.status     = STATUS_LOOKUP_MISS;
    r.proxy_ip   = '0;
    r.proxy_port = '0;
    r.proto      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (match_slot < 0 && shadow_key[base + w] == req_key) match_slot = base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    if (req.op == OP_LOOKUP) begin
      if (match_slot >= 0 && req.proto != 8'd0) begin
        r.hit    = 1'b1;
        r.status = STATUS_LOOKUP_HIT;
        {r.proxy_ip, r.proxy_port} = shadow_value[match_slot];
        r.proto  = PROTO_TCP;
      end
    end else if (match_slot >= 0) begin
      r.hit    = 1'b1;
      r.status = STATUS_PRESENT;
      {r.proxy_ip, r.proxy_port} = shadow_value[match_slot];
      r.proto  = PROTO_TCP;
    end else if (free_slot >= 0) begin
      shadow_valid[free_slot] = 1'b1;
      shadow_key[free_slot]   = req_key;
      shadow_value[free_slot] = {req.proxy_ip, req.proxy_port};
      r.status = STATUS_INSERTED;
    end else begin
      r.status = STATUS_FULL;
    end
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d, result %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, beats_out, field, got, want);
  endtask

  task automatic add_request(input op_t op, input logic [31:0] ip, input logic [15:0] port,
                             input logic [7:0] proto, input logic [31:0] lip,
                             input logic [15:0] lport);
    request_t req;
    req.op         = op;
    req.ip         = ip;
    req.port       = port;
    req.proto      = proto;
    req.proxy_ip   = lip;
    req.proxy_port = lport;
    pending_requests.push_back(req);
  endtask

  // Keys crowd into a few hot buckets so that buckets fill and keys repeat.
  task automatic build_key_pool();
    logic [7:0] hot_base;
    hot_base = 8'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom);
      if ($urandom_range(9) < 7) pool_ip[i][7:0] = hot_base + 8'($urandom_range(5));
      if (i > 0 && $urandom_range(4) == 0) pool_ip[i] = pool_ip[i - 1];
    end
  endtask

  task automatic add_random_requests(input int n);
    int       sel;
    int       pick;
    request_t req;
    for (int i = 0; i < n; i++) begin
      sel  = $urandom_range(99);
      pick = $urandom_range(POOL_SIZE - 1);
      req.ip         = pool_ip[pick];
      req.port       = pool_port[pick];
      req.proto      = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      req.proxy_ip   = $urandom;
      req.proxy_port = 16'($urandom);
      if (sel < 45) begin
        req.op = OP_LOOKUP;
      end else if (sel < 80) begin
        req.op = OP_INSERT;
      end else begin
        // Noise: any key at all, mostly landing in cold buckets.
        req.op    = op_t'($urandom_range(1));
        req.ip    = $urandom;
        req.port  = 16'($urandom);
        req.proto = 8'($urandom);
      end
      pending_requests.push_back(req);
    end
  endtask

  // Hold the sender off until every beat is out and every result is back.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Driver: presents the next pending beat, holding it until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        operation       <= pending_requests[0].op;
        key_ip          <= pending_requests[0].ip;
        key_port        <= pending_requests[0].port;
        proto_in        <= pending_requests[0].proto;
        new_listen_ip   <= pending_requests[0].proxy_ip;
        new_listen_port <= pending_requests[0].proxy_port;
        in_valid        <= 1'b1;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long output stall, counted here once it is armed.
  always @(negedge clk) begin
    if (stall_armed && stall_cycles < STALL_LEN) stall_cycles <= stall_cycles + 1;
  end

  // Receiver readiness.
  always @(negedge clk) begin
    if (rst || (stall_armed && stall_cycles < STALL_LEN))
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    reply_t   want;
    request_t req;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      req.op         = op_t'(operation);
      req.ip         = key_ip;
      req.port       = key_port;
      req.proto      = proto_in;
      req.proxy_ip   = new_listen_ip;
      req.proxy_port = new_listen_port;
      expected_replies.push_back(table_apply(req));
      beats_in++;
    end
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result beat, status", 32'(status), 32'd0);
      end else begin
        want = expected_replies.pop_front();
        status_seen[want.status]++;
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (found_listen_ip !== want.proxy_ip)
          report_mismatch("found_listen_ip", found_listen_ip, want.proxy_ip);
        if (found_listen_port !== want.proxy_port)
          report_mismatch("found_listen_port", 32'(found_listen_port), 32'(want.proxy_port));
        if (found_proto !== want.proto)
          report_mismatch("found_proto", 32'(found_proto), 32'(want.proto));
      end
    end
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) shadow_valid[i] = 1'b0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme keys and values, protocol zero, repeats.
    add_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'd6, 32'h0, 16'h0);
    add_request(OP_INSERT, 32'h0000_0000, 16'h0000, 8'd0, 32'hffff_ffff, 16'hffff);
    add_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'd6, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'd0, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'd255, 32'h0, 16'h0);
    add_request(OP_INSERT, 32'h0000_0000, 16'h0000, 8'd6, 32'h1234_5678, 16'h9abc);
    add_request(OP_INSERT, 32'hffff_ffff, 16'hffff, 8'd255, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'hffff_ffff, 16'hffff, 8'd1, 32'hffff_ffff, 16'hffff);
    add_request(OP_LOOKUP, 32'hffff_ffff, 16'h0000, 8'd6, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'h0000_00ff, 16'hffff, 8'd6, 32'h0, 16'h0);
    // Fill one bucket, overflow it, and revisit its keys.
    add_request(OP_INSERT, 32'h0000_005a, 16'h0050, 8'd6, 32'h0a00_0001, 16'h1f90);
    add_request(OP_INSERT, 32'h2000_015a, 16'h0050, 8'd6, 32'h0a00_0002, 16'h1f91);
    add_request(OP_INSERT, 32'he000_ff5a, 16'h01bb, 8'd6, 32'h0a00_0003, 16'h1f92);
    add_request(OP_INSERT, 32'h7fff_005a, 16'h8000, 8'd6, 32'h0a00_0004, 16'h1f93);
    add_request(OP_INSERT, 32'h1234_565a, 16'h0050, 8'd6, 32'h0a00_0005, 16'h1f94);
    add_request(OP_LOOKUP, 32'h1234_565a, 16'h0050, 8'd6, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'h7fff_005a, 16'h8000, 8'd17, 32'h0, 16'h0);
    add_request(OP_INSERT, 32'he000_ff5a, 16'h01bb, 8'd0, 32'hdead_beef, 16'h5555);
    add_request(OP_LOOKUP, 32'h2000_015a, 16'h0051, 8'd6, 32'h0, 16'h0);
    add_request(OP_LOOKUP, 32'h2000_015a, 16'h0050, 8'd0, 32'h0, 16'h0);
    wait_drained();

    // Sender sparse idling, receiver heavy idling.
    send_idle_pct = 21;
    recv_idle_pct = 70;
    build_key_pool();
    add_random_requests(PHASE_BEATS);
    wait_drained();

    // Roles swapped.
    send_idle_pct = 70;
    recv_idle_pct = 21;
    build_key_pool();
    add_random_requests(PHASE_BEATS);
    wait_drained();

    // No idling; a long output stall first lets the block back up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    build_key_pool();
    add_random_requests(PHASE_BEATS);
    stall_armed = 1'b1;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("results still missing", expected_replies.size(), 32'd0);

    $display("%0d beats in, %0d results out: %0d lookup hits, %0d misses, %0d inserts,",
             beats_in, beats_out, status_seen[STATUS_LOOKUP_HIT],
             status_seen[STATUS_LOOKUP_MISS], status_seen[STATUS_INSERTED]);
    $display("%0d repeat inserts, %0d full-bucket drops, %0d mismatches",
             status_seen[STATUS_PRESENT], status_seen[STATUS_FULL], error_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/hptt_pkg.sv
src/hptt_ram.sv
src/hptt_front.sv
src/hptt_back.sv
src/hashed_proxy_tuple_table_top.sv
src/hptt_checker.sv
test/testbench.sv
